/* rtl/core/ffsa_pkg.sv */
`default_nettype none
package ffsa_pkg;

    localparam int unsigned MaxSegmentsDefault = 64;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_POOL_BYTES  = 2'd1,
        CFG_DEF_ALIGN   = 2'd2,
        CFG_HEADER      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        in_use;
        logic [8:0]  locality;
        logic [31:0] user_addr;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RND_SIZE,
        S_RND_HDR,
        S_FREE_SCAN,
        S_FIT_SCAN,
        S_FIT_DIV,
        S_FIT_CHECK,
        S_INSERT,
        S_RESTORE,
        S_COAL,
        S_COAL_SHIFT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/core/first_fit_segment_allocator_unit.sv */
`default_nettype none
// First-fit segment allocator over one address pool.
// Requests arrive on the s_axis channel; tdata carries, from bit 0 up, req_size,
// req_align, req_locality and free_address, and tuser carries req_type (0 allocate,
// 1 free). One result word leaves on m_axis: status, user_address, granted_size.
// The segment table lives in a row of MAX_SEGMENTS cells that rotates by one entry
// a cycle while a walk advances, so the entry under work always sits in cell 0.
// A free walks the whole table. An allocate rounds the size and the header, then
// walks the table, skipping the other entries and giving each free candidate
// entry one serial 33-step alignment division; a split inserts one more entry.
// A failed allocate runs one coalesce pass and, if a merged segment is large
// enough, a second walk. One request is handled at a time; s_axis_tready is low
// while it is at work. The result is held in an output register until
// m_axis_tready takes it, and no new request is taken before then.
// Reset, and any write of pool_base or pool_bytes, puts the table back to one
// free segment covering the pool. The user must write configuration only while
// idle; the block itself does not enforce it.
module first_fit_segment_allocator_unit
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_size[31:0], req_align[44:32], req_locality[53:45], free_address[85:54]
    input  wire logic [87:0] s_axis_tdata,
    // req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], user_address[33:2], granted_size[65:34]
    output logic [71:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

    logic [31:0] r_pool_base, r_pool_bytes;
    logic [12:0] r_def_align;
    logic [8:0]  r_hdr_cfg;

    t_state r_state, n_state;
    logic [31:0]   r_size;
    logic [8:0]    r_loc;
    logic [31:0]   r_faddr;
    logic [12:0]   r_a;
    logic [32:0]   r_usz;
    logic [32:0]   r_hdr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic          r_wait;
    logic          r_retry;
    logic          r_found;
    logic [31:0]   r_best;
    logic [32:0]   r_v;
    t_seg          r_hold;
    t_status       r_st;
    logic [31:0]   r_uaddr, r_gsize;
    logic          r_ovalid;

    t_seg w_seg [MAX_SEGMENTS];
    logic w_init;
    t_seg w_init_seg;

    logic        div_start, div_busy;
    logic [32:0] div_num;
    logic [12:0] div_rem;

    logic        rot_all;
    logic        del_one;
    logic        app_one;
    t_seg        wrap_seg;
    t_seg        cell0_val;

    t_seg        c0, c1;
    logic [34:0] need_w, len_w;
    logic [33:0] nbytes_w;
    logic        match_w, hit_w, adj_w, take_w;
    logic [31:0] merged_len;
    logic [12:0] a_eff;
    logic [32:0] ru_w;

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;

    ffsa_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_a),
        .o_busy (div_busy),
        .o_rem  (div_rem)
    );

    assign w_init = !i_rst_n || (i_cfg_we &&
        (i_cfg_index == CFG_POOL_BASE || i_cfg_index == CFG_POOL_BYTES));
    always_comb begin
        w_init_seg.start     = (!i_rst_n) ? 32'd0 :
            (i_cfg_index == CFG_POOL_BASE) ? i_cfg_data : r_pool_base;
        w_init_seg.length    = (!i_rst_n) ? 32'd65536 :
            (i_cfg_index == CFG_POOL_BYTES) ? i_cfg_data : r_pool_bytes;
        w_init_seg.in_use    = 1'b0;
        w_init_seg.locality  = 9'h1FF;
        w_init_seg.user_addr = w_init_seg.start;
    end

    // Cell k takes from cell k+1 (the row moves towards cell 0) and the last live
    // entry takes the wrapped cell 0. Removing entry 1 shifts only cells above it,
    // and a new entry is appended just past the live ones.
    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            t_seg w_prev;
            logic w_rot;
            logic w_ld;
            t_seg w_ldv;
            always_comb begin
                if ((CW'(g) + CW'(1) == r_count) || (g + 1 >= MAX_SEGMENTS))
                    w_prev = wrap_seg;
                else
                    w_prev = w_seg[(g + 1) % MAX_SEGMENTS];
                w_rot = (rot_all && (CW'(g) < r_count)) ||
                        (del_one && (g != 0) && (CW'(g) + CW'(1) < r_count));
                w_ld  = ((g == 0) && del_one) || (app_one && (CW'(g) == r_count));
                w_ldv = (g == 0) ? cell0_val : r_hold;
            end
            ffsa_cell u_cell (
                .i_clk     (i_clk),
                .i_init    (w_init && (g == 0)),
                .i_init_seg(w_init_seg),
                .i_rotate  (w_rot),
                .i_prev    (w_prev),
                .i_load    (w_ld),
                .i_load_seg(w_ldv),
                .o_seg     (w_seg[g])
            );
        end
    endgenerate

    assign c0       = w_seg[0];
    assign c1       = w_seg[1];
    assign len_w    = {3'b0, c0.length};
    assign need_w   = {2'b0, r_usz} + {2'b0, r_hdr} + {2'b0, r_v} - {3'b0, c0.start};
    assign nbytes_w = {1'b0, r_usz} + {1'b0, r_hdr};
    assign match_w  = !c0.in_use && (c0.locality == r_loc);
    assign hit_w    = (c0.user_addr == r_faddr);
    assign adj_w    = !c0.in_use && !c1.in_use && (c0.locality == c1.locality) &&
                      (({1'b0, c0.start} + {1'b0, c0.length}) == {1'b0, c1.start});
    assign take_w   = !(len_w < need_w) && !(len_w > need_w && r_count >= CW'(MAX_SEGMENTS));
    assign merged_len = c0.length + c1.length;

    assign a_eff = (s_axis_tdata[44:32] != 13'd0) ? s_axis_tdata[44:32] :
                   (r_def_align != 13'd0) ? r_def_align : 13'd1;

    assign ru_w = (div_rem == 13'd0) ? div_num :
                  div_num + {20'd0, r_a} - {20'd0, div_rem};

    always_comb begin
        n_state   = r_state;
        rot_all   = 1'b0;
        del_one   = 1'b0;
        app_one   = 1'b0;
        wrap_seg  = c0;
        cell0_val = c0;
        cell0_val.length = merged_len;
        div_start = 1'b0;
        div_num   = '0;
        unique case (r_state)
            S_IDLE: if (s_acc) n_state = s_axis_tuser ? S_FREE_SCAN : S_RND_SIZE;
            S_RND_SIZE: begin
                div_num   = {1'b0, r_size};
                div_start = !r_wait;
                if (r_wait && !div_busy) n_state = S_RND_HDR;
            end
            S_RND_HDR: begin
                div_num   = r_hdr;
                div_start = !r_wait;
                if (r_wait && !div_busy) n_state = S_FIT_SCAN;
            end
            S_FREE_SCAN: begin
                rot_all = 1'b1;
                if (!r_found && hit_w) begin
                    wrap_seg.in_use   = 1'b0;
                    wrap_seg.locality = r_loc;
                end
                if (r_pos + CW'(1) >= r_count) n_state = S_DONE;
            end
            S_FIT_SCAN: begin
                if (r_pos >= r_count) begin
                    n_state = r_retry ? S_DONE : S_COAL;
                end else if (match_w) begin
                    n_state = S_FIT_DIV;
                end else begin
                    rot_all = 1'b1;
                end
            end
            S_FIT_DIV: begin
                div_num   = {1'b0, c0.start};
                div_start = !r_wait;
                if (r_wait && !div_busy) n_state = S_FIT_CHECK;
            end
            S_FIT_CHECK: begin
                if (len_w < need_w) begin
                    rot_all = 1'b1;
                    n_state = S_FIT_SCAN;
                end else if (!take_w) begin
                    n_state = S_RESTORE;
                end else begin
                    rot_all = 1'b1;
                    wrap_seg.in_use    = 1'b1;
                    wrap_seg.user_addr = r_v[31:0] + r_hdr[31:0];
                    if (len_w > need_w) begin
                        wrap_seg.length   = need_w[31:0];
                        wrap_seg.locality = r_loc;
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_RESTORE;
                    end
                end
            end
            S_INSERT: begin
                app_one = 1'b1;
                n_state = S_RESTORE;
            end
            S_RESTORE: begin
                if (r_pos >= r_count) n_state = S_DONE;
                else rot_all = 1'b1;
            end
            S_COAL: begin
                if (r_pos >= r_count) begin
                    n_state = ({2'b0, r_best} >= nbytes_w) ? S_FIT_SCAN : S_DONE;
                end else if ((r_pos + CW'(1) < r_count) && adj_w) begin
                    del_one = 1'b1;
                    n_state = S_COAL_SHIFT;
                end else begin
                    rot_all = 1'b1;
                end
            end
            S_COAL_SHIFT: begin
                rot_all = 1'b1;
                n_state = S_COAL;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= 32'd0;
            r_pool_bytes <= 32'd65536;
            r_def_align  <= 13'd8;
            r_hdr_cfg    <= 9'd48;
            r_count      <= CW'(1);
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_POOL_BASE:  r_pool_base <= i_cfg_data;
                    CFG_POOL_BYTES: r_pool_bytes <= i_cfg_data;
                    CFG_DEF_ALIGN:  r_def_align <= i_cfg_data[12:0];
                    CFG_HEADER:     r_hdr_cfg <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (w_init) r_count <= CW'(1);
            else if (app_one) r_count <= r_count + CW'(1);
            else if (del_one) r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;

            if (div_start) r_wait <= 1'b1;
            else if (r_wait && !div_busy) r_wait <= 1'b0;

            if (s_acc) r_pos <= '0;
            else if ((r_state == S_FIT_SCAN && n_state == S_COAL) ||
                     (r_state == S_COAL && n_state == S_FIT_SCAN)) r_pos <= '0;
            else if (rot_all || app_one) r_pos <= r_pos + CW'(1);

            case (r_state)
                S_IDLE: if (s_acc) begin
                    r_size  <= s_axis_tdata[31:0];
                    r_loc   <= s_axis_tdata[53:45];
                    r_faddr <= s_axis_tdata[85:54];
                    r_a     <= a_eff;
                    r_hdr   <= {24'd0, r_hdr_cfg};
                    r_found <= 1'b0;
                    r_retry <= 1'b0;
                    r_st    <= ST_NO_FIT;
                    r_uaddr <= '0;
                    r_gsize <= '0;
                end
                S_RND_SIZE: if (r_wait && !div_busy) r_usz <= ru_w;
                S_RND_HDR:  if (r_wait && !div_busy) r_hdr <= ru_w;
                S_FREE_SCAN: begin
                    if (hit_w) r_found <= 1'b1;
                    if (r_pos + CW'(1) >= r_count)
                        r_st <= (r_found || hit_w) ? ST_OK : ST_NO_FIT;
                end
                S_FIT_SCAN: if (r_pos >= r_count && !r_retry) begin
                    r_retry <= 1'b1;
                    r_best  <= '0;
                end
                S_FIT_DIV: if (r_wait && !div_busy) r_v <= ru_w;
                S_FIT_CHECK: if (!(len_w < need_w)) begin
                    if (!take_w) begin
                        r_st <= ST_FULL;
                    end else begin
                        r_st    <= ST_OK;
                        r_uaddr <= r_v[31:0] + r_hdr[31:0];
                        r_gsize <= r_usz[31:0];
                        r_hold.start     <= r_v[31:0] + r_usz[31:0] + r_hdr[31:0];
                        r_hold.length    <= c0.length - need_w[31:0];
                        r_hold.in_use    <= 1'b0;
                        r_hold.locality  <= r_loc;
                        r_hold.user_addr <= r_v[31:0] + r_usz[31:0] + r_hdr[31:0];
                    end
                end
                S_COAL: if (del_one && r_best < merged_len) r_best <= merged_len;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_gsize, r_uaddr, r_st};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> s_axis_tready == 1'b0) else $error("input taken with result pending");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= CW'(MAX_SEGMENTS)) else $error("segment count out of range");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_ovalid) else $error("result lost");
    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_st != ST_RESERVED) else $error("bad status");
endmodule
`default_nettype wire

/* rtl/core/ffsa_divider.sv */
`default_nettype none
module ffsa_divider
    import ffsa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_num,
    input  wire logic [12:0] i_den,
    output logic             o_busy,
    output logic [12:0]      o_rem
);
    // Restoring division, one quotient bit a cycle.
    logic [5:0]  r_cnt;
    logic [32:0] r_q;
    logic [12:0] r_r;
    logic [14:0] n_trial;

    assign n_trial = {1'b0, r_r, r_q[32]} - {2'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd33;
            r_q   <= i_num;
            r_r   <= '0;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            if (!n_trial[14]) begin
                r_r <= n_trial[12:0];
                r_q <= {r_q[31:0], 1'b1};
            end else begin
                r_r <= {r_r[11:0], r_q[32]};
                r_q <= {r_q[31:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != 6'd0) || i_start;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

/* rtl/core/ffsa_cell.sv */
`default_nettype none
module ffsa_cell
    import ffsa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_init,
    input  wire t_seg i_init_seg,
    input  wire logic i_rotate,
    input  wire t_seg i_prev,
    input  wire logic i_load,
    input  wire t_seg i_load_seg,
    output t_seg      o_seg
);
    // One table entry; the row rotates so that cell 0 always holds the entry under work.
    t_seg r_seg;

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_seg <= i_init_seg;
        end else if (i_load) begin
            r_seg <= i_load_seg;
        end else if (i_rotate) begin
            r_seg <= i_prev;
        end
    end

    assign o_seg = r_seg;
endmodule
`default_nettype wire

/* sim/first_fit_segment_allocator_unit_checker.sv */
module first_fit_segment_allocator_unit_checker
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [87:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_grants,
    output int               o_full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [31:0] addr;
        logic [31:0] size;
    } t_reply;

    logic [31:0] base_q, bytes_q;
    logic [12:0] align_q;
    logic [8:0]  hdr_q;
    t_seg        segs[MAX_SEGMENTS];
    int unsigned nsegs;
    t_reply      replies[$];

    function automatic logic [63:0] round_to(logic [63:0] x, logic [63:0] a);
        return ((x + a - 1) / a) * a;
    endfunction

    function automatic void table_reset();
        foreach (segs[i]) segs[i] = '0;
        segs[0].start = base_q;
        segs[0].length = bytes_q;
        segs[0].locality = 9'h1FF;
        segs[0].user_addr = base_q;
        nsegs = 1;
    endfunction

    function automatic t_status fit(logic [63:0] a, logic [63:0] usz, logic [63:0] hdr,
                                    logic [8:0] loc, output logic [31:0] addr);
        logic [63:0] nbytes, u, v, need, len;
        nbytes = usz + hdr;
        addr = '0;
        for (int i = 0; i < nsegs; i++) begin
            if (segs[i].in_use || segs[i].locality != loc) continue;
            len = segs[i].length;
            u = segs[i].start;
            v = round_to(u, a);
            need = nbytes + (v - u);
            if (len < need) continue;
            if (len > need) begin
                if (nsegs >= MAX_SEGMENTS) return ST_FULL;
                for (int k = nsegs; k > i + 1; k--) segs[k] = segs[k-1];
                segs[i+1].start = 32'(v + nbytes);
                segs[i+1].length = 32'(len - need);
                segs[i+1].in_use = 1'b0;
                segs[i+1].locality = loc;
                segs[i+1].user_addr = 32'(v + nbytes);
                nsegs++;
                segs[i].length = 32'(need);
                segs[i].locality = loc;
            end
            segs[i].user_addr = 32'(v + hdr);
            segs[i].in_use = 1'b1;
            addr = segs[i].user_addr;
            return ST_OK;
        end
        return ST_NO_FIT;
    endfunction

    function automatic logic [63:0] merge_free();
        logic [63:0] largest;
        largest = 0;
        for (int i = 0; i + 1 < nsegs; i++) begin
            if (segs[i].in_use || segs[i+1].in_use
                    || segs[i].locality != segs[i+1].locality) continue;
            if (64'(segs[i].start) + segs[i].length != 64'(segs[i+1].start)) continue;
            segs[i].length = segs[i].length + segs[i+1].length;
            if (largest < segs[i].length) largest = segs[i].length;
            for (int k = i + 1; k + 1 < nsegs; k++) segs[k] = segs[k+1];
            nsegs--;
        end
        return largest;
    endfunction

    function automatic t_reply serve(logic is_free, logic [31:0] size, logic [12:0] align,
                                     logic [8:0] loc, logic [31:0] faddr);
        t_reply r;
        logic [63:0] a, usz, hdr;
        logic [31:0] addr;
        r = '{ST_NO_FIT, 32'd0, 32'd0};
        if (is_free) begin
            for (int i = 0; i < nsegs; i++) begin
                if (segs[i].user_addr == faddr) begin
                    segs[i].in_use = 1'b0;
                    segs[i].locality = loc;
                    r.status = ST_OK;
                    break;
                end
            end
            return r;
        end
        a = (align == 0) ? 64'(align_q) : 64'(align);
        if (a == 0) a = 1;
        usz = round_to(64'(size), a);
        hdr = round_to(64'(hdr_q), a);
        r.status = fit(a, usz, hdr, loc, addr);
        if (r.status == ST_NO_FIT && merge_free() >= usz + hdr)
            r.status = fit(a, usz, hdr, loc, addr);
        if (r.status == ST_OK) begin
            r.addr = addr;
            r.size = usz[31:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want, got;
        if (!i_rst_n) begin
            base_q = '0;
            bytes_q = 32'd65536;
            align_q = 13'd8;
            hdr_q = 9'd48;
            table_reset();
            replies.delete();
            o_errors <= 0;
            o_grants <= 0;
            o_full_hits <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_POOL_BASE: begin
                        base_q = i_cfg_data;
                        table_reset();
                    end
                    CFG_POOL_BYTES: begin
                        bytes_q = i_cfg_data;
                        table_reset();
                    end
                    CFG_DEF_ALIGN: align_q = i_cfg_data[12:0];
                    CFG_HEADER: hdr_q = i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = serve(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[44:32],
                             s_axis_tdata[53:45], s_axis_tdata[85:54]);
                replies.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{t_status'(m_axis_tdata[1:0]), m_axis_tdata[33:2], m_axis_tdata[65:34]};
                if (replies.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result word %h", m_axis_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = replies.pop_front();
                    if (got != want) begin
                        if (o_errors < 10)
                            $display("mismatch: expected st=%0d addr=%h size=%h, got st=%0d addr=%h size=%h",
                                     want.status, want.addr, want.size,
                                     got.status, got.addr, got.size);
                        o_errors <= o_errors + 1;
                    end
                    if (want.status == ST_OK && want.size != 0) o_grants <= o_grants + 1;
                    if (want.status == ST_FULL) o_full_hits <= o_full_hits + 1;
                end
            end
        end
    end

    assign o_pending = replies.size();

endmodule

/* sim/first_fit_segment_allocator_unit_tb.sv */
module first_fit_segment_allocator_unit_tb;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending, grants, full_hits;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          timed_out = 1'b0;
    logic [31:0] granted[$];

    localparam int IdleLimit = 200000;

    always #1 i_clk = ~i_clk;

    first_fit_segment_allocator_unit dut (.*);

    first_fit_segment_allocator_unit_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .i_cfg_we, .i_cfg_index,
        .i_cfg_data, .o_errors(errors), .o_pending(pending), .o_grants(grants),
        .o_full_hits(full_hits)
    );

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit && !timed_out) begin
            timed_out <= 1'b1;
            $display("first_fit_segment_allocator_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0) || sent[6];
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == ST_OK
                && m_axis_tdata[65:34] != 0 && granted.size() < 256)
            granted.push_back(m_axis_tdata[33:2]);
    end

    task automatic send_word(logic is_free, logic [31:0] size, logic [12:0] align,
                             logic [8:0] loc, logic [31:0] faddr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= is_free;
        s_axis_tdata <= {2'b00, faddr, loc, align, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if ($urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [8:0] pick_loc();
        case ($urandom_range(0, 3))
            0, 1: return 9'h1FF;
            2:    return 9'($urandom_range(0, 3));
            default: return 9'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_phase(int count, int max_size);
        logic [31:0] faddr;
        repeat (count) begin
            if ($urandom_range(0, 9) < 4 && granted.size() > 0) begin
                faddr = granted[$urandom_range(0, granted.size() - 1)];
                if ($urandom_range(0, 9) == 0) faddr = $urandom;
                send_word(1'b1, $urandom, 13'($urandom), pick_loc(), faddr);
            end else begin
                send_word(1'b0, ($urandom_range(0, 19) == 0) ? $urandom
                                                             : $urandom_range(0, max_size),
                          ($urandom_range(0, 3) == 0) ? 13'd0
                                                      : 13'($urandom_range(1, 4096)),
                          pick_loc(), $urandom);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(1'b0, 32'd0, 13'd0, 9'h1FF, 32'd0);
        send_word(1'b0, 32'hFFFF_FFFF, 13'd4096, 9'h1FF, 32'hFFFF_FFFF);
        send_word(1'b0, 32'd100, 13'd3, 9'h1FF, 32'd0);
        send_word(1'b0, 32'd1000, 13'd4096, 9'h1FF, 32'd0);
        send_word(1'b0, 32'd64, 13'd1, 9'd255, 32'd0);
        send_word(1'b1, 32'hFFFF_FFFF, 13'h1FFF, 9'd7, 32'h0000_0030);
        send_word(1'b1, 32'd0, 13'd0, 9'h1FF, 32'hDEAD_BEEF);
        send_word(1'b1, 32'd0, 13'd0, 9'h1FF, 32'd0);
        send_word(1'b0, 32'd16, 13'd8, 9'd7, 32'd0);
        drain();

        write_reg(CFG_DEF_ALIGN, 32'd0);
        write_reg(CFG_HEADER, 32'd0);
        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        write_reg(CFG_POOL_BYTES, 32'd8192);
        for (int i = 0; i < 70; i++)
            send_word(1'b0, 32'd8, 13'd0, 9'h1FF, 32'd0);
        send_word(1'b0, 32'd16384, 13'd0, 9'h1FF, 32'd0);
        drain();

        write_reg(CFG_POOL_BASE, 32'd0);
        write_reg(CFG_POOL_BYTES, 32'hFFFF_FFFF);
        write_reg(CFG_DEF_ALIGN, 32'd4096);
        write_reg(CFG_HEADER, 32'd256);
        send_word(1'b0, 32'hFFFF_0000, 13'd0, 9'h1FF, 32'd0);
        send_word(1'b0, 32'd0, 13'd0, 9'h1FF, 32'd0);
        drain();
        write_reg(CFG_POOL_BYTES, 32'd0);
        send_word(1'b0, 32'd0, 13'd1, 9'h1FF, 32'd0);
        drain();

        granted.delete();
        write_reg(CFG_POOL_BASE, 32'h1000_0000);
        write_reg(CFG_POOL_BYTES, 32'd65536);
        write_reg(CFG_DEF_ALIGN, 32'd8);
        write_reg(CFG_HEADER, 32'd48);
        fork
            begin
                hold_off <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            random_phase(10, 512);
        join
        random_phase(390, 2048);
        drain();

        granted.delete();
        write_reg(CFG_DEF_ALIGN, 32'd1);
        write_reg(CFG_HEADER, 32'd1);
        write_reg(CFG_POOL_BASE, 32'd3);
        write_reg(CFG_POOL_BYTES, 32'd4000);
        random_phase(400, 300);
        drain();

        granted.delete();
        write_reg(CFG_DEF_ALIGN, 32'd24);
        write_reg(CFG_HEADER, 32'd17);
        write_reg(CFG_POOL_BYTES, 32'd200000);
        random_phase(320, 9000);
        drain();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d request words over several pool settings: %0d grants, %0d table-full replies.",
                 sent, grants, full_hits);
        if (errors == 0)
            $display("first_fit_segment_allocator_unit_tb: PASS");
        else
            $display("first_fit_segment_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule
